// File: hdl/bta_pkg.sv
// Package for the block table allocator: payload structs, opcode, status and
// kind codes, and the command/status structs between controller and datapath.
// No dependencies.
package bta_pkg;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_ALLOCATE   = 3'd1;
    localparam logic [2:0] OP_RELEASE    = 3'd2;
    localparam logic [2:0] OP_FIND_ADDR  = 3'd3;
    localparam logic [2:0] OP_FIND_OWNER = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    localparam logic [1:0] KIND_BLOCK    = 2'd2;

    localparam logic [0:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [0:0] CFG_HEAP_BYTES = 1'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] request_size;
        logic [31:0] owner_tag;
        logic [31:0] lookup_address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [5:0]  entry_index;
        logic [31:0] block_size;
        logic [1:0]  block_kind;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the input word, restart the scan
        logic clear;      // clear operation
        logic scan;       // issue a table read at the scan index and advance it
        logic commit;     // apply the allocate decision
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;  // every live entry has been issued
    } dp_stat_t;

endpackage

// File: hdl/block_table_allocator.sv
// Top level of the block table allocator.
// Depends on bta_pkg, bta_ctrl, bta_datapath.
//
// One word at a time: the block keeps its descriptors in registered-read
// memories and scans the N live entries one per cycle, so allocate, release
// and both finds give their result word after the scan and the commit state.
// Allocate tracks the first released entry that fits and the smallest
// released entry in the same pass, then reuses, appends or recycles in the
// commit state. Clear and unknown opcodes skip the scan and go straight to
// the output state. Released flags sit in memory beside each entry and are
// written whenever an entry is appended, so clear only resets the count and
// the heap pointer. The result word is held until the output side takes it,
// and no input word is taken meanwhile. Configuration writes are always
// accepted and must be made only while the block is idle.
module block_table_allocator #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bta_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bta_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    bta_pkg::dp_cmd_t  cmd;
    bta_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bta_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_opcode(in_data.opcode), .in_stall,
        .out_valid, .out_stall, .cmd, .stat
    );

    bta_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk, .rst_n, .in_word(in_data), .cfg_we(cfg_valid & cfg_ready),
        .cfg_idx(cfg_index), .cfg_data, .cmd, .stat, .out_word(out_data)
    );

`ifndef SYNTH
    // A word is never taken while a result is pending.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    // A result held under stall stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
`endif
endmodule

// File: hdl/bta_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module bta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/bta_datapath.sv
// Datapath of the block table allocator: table memories, scan pipeline,
// heap pointer and result word. Depends on bta_pkg, bta_ram.
module bta_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bta_pkg::in_word_t  in_word,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic [31:0]        cfg_data,
    input  bta_pkg::dp_cmd_t   cmd,
    output bta_pkg::dp_stat_t  stat,
    output bta_pkg::out_word_t out_word
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [31:0]   heap_base_reg, heap_bytes_reg, heap_top_reg, heap_top_next;
    logic [CW-1:0] count_reg, count_next;

    bta_pkg::in_word_t req_reg;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          ev_valid_reg;
    logic [IW-1:0] ev_idx_reg;

    // First released entry that fits the request.
    logic          fit_found_reg, fit_found_next;
    logic [IW-1:0] fit_idx_reg, fit_idx_next;
    logic [31:0]   fit_addr_reg, fit_addr_next, fit_size_reg, fit_size_next;
    // Smallest released entry, the later one on equal sizes.
    logic          sm_found_reg, sm_found_next;
    logic [IW-1:0] sm_idx_reg, sm_idx_next;
    logic [31:0]   sm_addr_reg, sm_addr_next, sm_size_reg, sm_size_next;

    logic               find_hit_reg, find_hit_next;
    bta_pkg::out_word_t res_reg, res_next;

    logic [31:0]   rd_addr, rd_size, rd_owner;
    logic [1:0]    rd_kind;
    logic          rd_rel;
    logic [IW-1:0] raddr, waddr;
    logic          we_geo, we_kind, we_own;
    logic [31:0]   w_owner;
    logic          w_rel;

    logic          is_alloc, is_rel, is_find_addr, is_find_owner;
    logic          size_zero, full, ovf, reuse, find_match;
    logic [31:0]   span, aligned;
    logic [IW-1:0] new_idx;

    bta_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr (.clk, .we(we_geo),
        .waddr, .wdata(heap_top_reg), .raddr, .rdata(rd_addr));
    bta_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_size (.clk, .we(we_geo),
        .waddr, .wdata(aligned), .raddr, .rdata(rd_size));
    bta_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_owner (.clk, .we(we_own),
        .waddr, .wdata(w_owner), .raddr, .rdata(rd_owner));
    bta_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_rel (.clk, .we(we_own),
        .waddr, .wdata(w_rel), .raddr, .rdata(rd_rel));
    bta_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_kind (.clk, .we(we_kind),
        .waddr, .wdata(bta_pkg::KIND_BLOCK), .raddr, .rdata(rd_kind));

    always_comb
    begin
        raddr         = IW'(scan_idx_reg);
        is_alloc      = (req_reg.opcode == bta_pkg::OP_ALLOCATE);
        is_rel        = (req_reg.opcode == bta_pkg::OP_RELEASE);
        is_find_addr  = (req_reg.opcode == bta_pkg::OP_FIND_ADDR);
        is_find_owner = (req_reg.opcode == bta_pkg::OP_FIND_OWNER);
        size_zero     = (req_reg.request_size == '0);
        full          = (count_reg == CW'(TABLE_ENTRIES));
        span          = heap_top_reg + req_reg.request_size - heap_base_reg;
        ovf           = !(span < heap_bytes_reg);
        aligned       = ((req_reg.request_size + 32'd15) >> 4) << 4;
        reuse         = size_zero ? sm_found_reg : fit_found_reg;
        new_idx       = full ? sm_idx_reg : IW'(count_reg);
        find_match    = is_find_addr
                        ? (rd_addr == req_reg.lookup_address && rd_addr != '0)
                        : (rd_owner == req_reg.owner_tag);

        stat.scan_done = (scan_idx_reg == count_reg);

        scan_idx_next  = scan_idx_reg;
        fit_found_next = fit_found_reg;
        fit_idx_next   = fit_idx_reg;
        fit_addr_next  = fit_addr_reg;
        fit_size_next  = fit_size_reg;
        sm_found_next  = sm_found_reg;
        sm_idx_next    = sm_idx_reg;
        sm_addr_next   = sm_addr_reg;
        sm_size_next   = sm_size_reg;
        find_hit_next  = find_hit_reg;
        res_next       = res_reg;
        heap_top_next  = heap_top_reg;
        count_next     = count_reg;

        waddr   = ev_idx_reg;
        we_geo  = 1'b0;
        we_kind = 1'b0;
        we_own  = 1'b0;
        w_owner = req_reg.owner_tag;
        w_rel   = 1'b0;

        if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
        end

        // Read data of the entry issued in the previous cycle.
        if (ev_valid_reg)
        begin
            if (is_alloc && rd_rel)
            begin
                if (!size_zero && !fit_found_reg && rd_size >= req_reg.request_size)
                begin
                    fit_found_next = 1'b1;
                    fit_idx_next   = ev_idx_reg;
                    fit_addr_next  = rd_addr;
                    fit_size_next  = rd_size;
                end
                if (!sm_found_reg || sm_size_reg >= rd_size)
                begin
                    sm_found_next = 1'b1;
                    sm_idx_next   = ev_idx_reg;
                    sm_addr_next  = rd_addr;
                    sm_size_next  = rd_size;
                end
            end
            if (is_rel && rd_owner == req_reg.owner_tag)
            begin
                we_own  = 1'b1;
                w_owner = '0;
                w_rel   = 1'b1;
            end
            if ((is_find_addr || is_find_owner) && !find_hit_reg && find_match)
            begin
                find_hit_next          = 1'b1;
                res_next.status        = bta_pkg::ST_OK;
                res_next.block_address = rd_addr;
                res_next.entry_index   = 6'(ev_idx_reg);
                res_next.block_size    = rd_size;
                res_next.block_kind    = rd_kind;
            end
        end

        if (cmd.commit && is_alloc)
        begin
            if (reuse)
            begin
                waddr   = size_zero ? sm_idx_reg : fit_idx_reg;
                we_own  = 1'b1;
                we_kind = 1'b1;
                res_next.status        = bta_pkg::ST_OK;
                res_next.block_address = size_zero ? sm_addr_reg : fit_addr_reg;
                res_next.entry_index   = 6'(waddr);
                res_next.block_size    = size_zero ? sm_size_reg : fit_size_reg;
                res_next.block_kind    = bta_pkg::KIND_BLOCK;
            end
            else if (full && !sm_found_reg)
            begin
                res_next.status = bta_pkg::ST_TABLE_FULL;
            end
            else if (ovf)
            begin
                res_next.status = bta_pkg::ST_OVERFLOW;
            end
            else
            begin
                waddr   = new_idx;
                we_geo  = 1'b1;
                we_kind = 1'b1;
                we_own  = 1'b1;
                if (!full)
                begin
                    count_next = count_reg + CW'(1);
                end
                heap_top_next          = heap_top_reg + aligned;
                res_next.status        = bta_pkg::ST_OK;
                res_next.block_address = heap_top_reg;
                res_next.entry_index   = 6'(new_idx);
                res_next.block_size    = aligned;
                res_next.block_kind    = bta_pkg::KIND_BLOCK;
            end
        end

        if (cmd.load)
        begin
            scan_idx_next  = '0;
            fit_found_next = 1'b0;
            sm_found_next  = 1'b0;
            find_hit_next  = 1'b0;
            res_next       = '0;
            if (in_word.opcode >= bta_pkg::OP_FIND_ADDR)
            begin
                res_next.status = bta_pkg::ST_NOT_FOUND;
            end
        end
        if (cmd.clear)
        begin
            heap_top_next = heap_base_reg;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= '0;
            heap_top_reg   <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            ev_valid_reg   <= 1'b0;
            fit_found_reg  <= 1'b0;
            sm_found_reg   <= 1'b0;
            find_hit_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == bta_pkg::CFG_HEAP_BASE) heap_base_reg <= cfg_data;
            if (cfg_we && cfg_idx == bta_pkg::CFG_HEAP_BYTES) heap_bytes_reg <= cfg_data;
            heap_top_reg  <= heap_top_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            ev_valid_reg  <= cmd.scan;
            fit_found_reg <= fit_found_next;
            sm_found_reg  <= sm_found_next;
            find_hit_reg  <= find_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) req_reg <= in_word;
        ev_idx_reg   <= raddr;
        fit_idx_reg  <= fit_idx_next;
        fit_addr_reg <= fit_addr_next;
        fit_size_reg <= fit_size_next;
        sm_idx_reg   <= sm_idx_next;
        sm_addr_reg  <= sm_addr_next;
        sm_size_reg  <= sm_size_next;
        res_reg      <= res_next;
    end

    assign out_word = res_reg;
endmodule

// File: hdl/bta_ctrl.sv
// Controller of the block table allocator: sequences load, scan, commit and
// output. Depends on bta_pkg.
module bta_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        in_opcode,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bta_pkg::dp_cmd_t  cmd,
    input  bta_pkg::dp_stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_opcode == bta_pkg::OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (in_opcode > bta_pkg::OP_FIND_OWNER)
                        state_next = S_OUT;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The cycle after the last issue evaluates the last entry.
                if (stat.scan_done)
                    state_next = S_COMMIT;
                else
                    cmd.scan = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
